@@ design/base64_stream_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_macros
// assertion macros used by the decoder's top-level rtl file
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// same-cycle implication
`define B64SD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define B64SD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/b64sd_pkg.sv @@
// ----------------------------------------------------------------------------
// b64sd_pkg
// types and constants of the base64 stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64sd_pkg;

   localparam int unsigned COUNT_BITS_DEFAULT = 16;
   localparam int unsigned CSR_DATA_BITS      = 16;
   localparam logic [15:0] OUTPUT_LIMIT_RESET = 16'hFFFF;

   typedef enum logic {
      CSR_URL_MODE     = 1'b0,
      CSR_OUTPUT_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_PROGRESS = 3'd0,
      ST_OK       = 3'd1,
      ST_INVALID  = 3'd2,
      ST_PADDING  = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_PAD,
      KIND_SPACE,
      KIND_INVALID
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  value;
   } class_type;

   typedef struct packed {
      class_type   cls;
      logic        last;
   } step_type;

   typedef struct packed {
      logic [7:0]  in_char;
      logic        last_char;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      status_type  status;
      logic        message_end;
      logic [15:0] byte_count;
   } rsp_payload_type;

endpackage

`default_nettype wire

@@ design/b64sd_stream_if.sv @@
// ----------------------------------------------------------------------------
// b64sd_stream_if
// valid/ready word channel with a typed payload
// ----------------------------------------------------------------------------
`default_nettype none

interface b64sd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/b64sd_classify.sv @@
// ----------------------------------------------------------------------------
// b64sd_classify
// maps one character to a 6-bit value, padding, whitespace or invalid
// ----------------------------------------------------------------------------
`default_nettype none

module b64sd_classify (
   input  wire logic [7:0]          in_char,
   input  wire logic                url_safe,
   output b64sd_pkg::class_type     cls
);
   import b64sd_pkg::*;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;
   localparam logic [5:0] VAL_62     = 6'd62;
   localparam logic [5:0] VAL_63     = 6'd63;

   always_comb begin
      cls.kind  = KIND_INVALID;
      cls.value = '0;
      if (in_char >= CH_UPPER_A && in_char <= CH_UPPER_Z) begin
         cls.kind  = KIND_DATA;
         cls.value = 6'(in_char - CH_UPPER_A);
      end else if (in_char >= CH_LOWER_A && in_char <= CH_LOWER_Z) begin
         cls.kind  = KIND_DATA;
         cls.value = 6'(in_char - CH_LOWER_A + LOWER_BASE);
      end else if (in_char >= CH_DIGIT_0 && in_char <= CH_DIGIT_9) begin
         cls.kind  = KIND_DATA;
         cls.value = 6'(in_char - CH_DIGIT_0 + DIGIT_BASE);
      end else if (in_char == (url_safe ? CH_MINUS : CH_PLUS)) begin
         cls.kind  = KIND_DATA;
         cls.value = VAL_62;
      end else if (in_char == (url_safe ? CH_UNDER : CH_SLASH)) begin
         cls.kind  = KIND_DATA;
         cls.value = VAL_63;
      end else if (in_char == CH_EQUAL) begin
         cls.kind  = KIND_PAD;
      end else if (in_char == CH_SPACE || in_char == CH_TAB ||
                   in_char == CH_CR || in_char == CH_LF) begin
         cls.kind  = KIND_SPACE;
      end
   end

endmodule

`default_nettype wire

@@ design/b64sd_decode.sv @@
// ----------------------------------------------------------------------------
// b64sd_decode
// message state: bit accumulator, padding, byte count and error discard
// ----------------------------------------------------------------------------
`default_nettype none

module b64sd_decode #(
   parameter int unsigned COUNT_BITS = b64sd_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   url_safe,
   input  wire logic [15:0]            output_limit,
   input  wire logic [7:0]             in_char,
   input  wire logic                   last_char,
   input  wire logic                   advance,
   output logic                        res_valid,
   output b64sd_pkg::rsp_payload_type  res
);
   import b64sd_pkg::*;

   localparam int unsigned CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   class_type              cls;
   logic [11:0]            acc_ff, acc_in;
   logic [3:0]             held_ff, held_in, held_sum;
   logic                   pad_ff, pad_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in, count_res;
   logic                   discard_ff, discard_in;
   logic                   limit_hit;
   logic [CW-1:0]          count_wide;
   status_type             status;
   logic [7:0]             out_byte;
   logic                   byte_valid;

   b64sd_classify u_classify (
      .in_char  (in_char),
      .url_safe (url_safe),
      .cls      (cls)
   );

   assign limit_hit = (CW'(count_ff) >= CW'(output_limit)) || (count_ff == '1);
   assign held_sum  = held_ff + 4'd6;

   always_comb begin
      acc_in     = acc_ff;
      held_in    = held_ff;
      pad_in     = pad_ff;
      count_in   = count_ff;
      discard_in = discard_ff;
      status     = ST_PROGRESS;
      out_byte   = '0;
      byte_valid = 1'b0;
      if (!discard_ff) begin
         case (cls.kind)
            KIND_INVALID: status = ST_INVALID;
            KIND_PAD:     pad_in = 1'b1;
            KIND_SPACE:   ;
            default: begin
               if (pad_ff) begin
                  status = ST_PADDING;
               end else begin
                  acc_in = {acc_ff[5:0], cls.value};
                  if (held_sum >= 4'd8) begin
                     held_in = held_sum - 4'd8;
                     if (limit_hit) begin
                        status = ST_OVERFLOW;
                     end else begin
                        out_byte   = 8'(acc_in >> held_in[2:0]);
                        byte_valid = 1'b1;
                        count_in   = COUNT_BITS'(count_ff + 1'b1);
                     end
                  end else begin
                     held_in = held_sum;
                  end
               end
            end
         endcase
      end
      count_res = count_in;
      res_valid = !discard_ff && (status != ST_PROGRESS || last_char || byte_valid);
      if (!discard_ff && status != ST_PROGRESS && !last_char) begin
         discard_in = 1'b1;
      end else if (!discard_ff && status == ST_PROGRESS && last_char) begin
         status = ST_OK;
      end
      if (last_char) begin
         acc_in     = '0;
         held_in    = '0;
         pad_in     = 1'b0;
         count_in   = '0;
         discard_in = 1'b0;
      end
   end

   assign count_wide = CW'(count_res);
   assign res        = rsp_payload_type'{out_byte, byte_valid, status,
                                         (status != ST_PROGRESS), count_wide[15:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         held_ff    <= '0;
         pad_ff     <= 1'b0;
         count_ff   <= '0;
         discard_ff <= 1'b0;
      end else if (advance) begin
         acc_ff     <= acc_in;
         held_ff    <= held_in;
         pad_ff     <= pad_in;
         count_ff   <= count_in;
         discard_ff <= discard_in;
      end
   end

endmodule

`default_nettype wire

@@ design/base64_stream_decoder.sv @@
// path: an accepted character is held in the input register, decoded
//    combinationally and its result word registered in the result register
// throughput: one character per cycle while the result side does not stall
// reset: synchronous, clears message state and pipeline valids,
//    alphabet to standard, output_limit to 65535
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 decoder, one character in, at most one byte out
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder #(
   parameter int unsigned COUNT_BITS = b64sd_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   b64sd_stream_if.sink                              req_if,
   b64sd_stream_if.source                            rsp_if,
   input  wire logic                                 csr_we,
   input  wire b64sd_pkg::csr_index_type             csr_index,
   input  wire logic [b64sd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import b64sd_pkg::*;

   logic              url_ff;
   logic [15:0]       limit_ff;
   logic              s1_valid_ff, s1_valid_in;
   req_payload_type   s1_data_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_payload_type   out_data_ff;
   logic              out_free;
   logic              s1_adv;
   logic              req_take;
   logic              res_valid;
   rsp_payload_type   res;

   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign req_take     = req_if.valid && req_if.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign out_valid_in = out_free ? (s1_adv && res_valid) : out_valid_ff;

   b64sd_decode #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decode (
      .clock        (clock),
      .reset        (reset),
      .url_safe     (url_ff),
      .output_limit (limit_ff),
      .in_char      (s1_data_ff.in_char),
      .last_char    (s1_data_ff.last_char),
      .advance      (s1_adv),
      .res_valid    (res_valid),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         url_ff       <= 1'b0;
         limit_ff     <= OUTPUT_LIMIT_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_URL_MODE:     url_ff   <= csr_wdata[0];
               CSR_OUTPUT_LIMIT: limit_ff <= csr_wdata[15:0];
               default:          ;
            endcase
         end
      end
      if (req_take) begin
         s1_data_ff <= req_if.payload;
      end
      if (out_free) begin
         out_data_ff <= res;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

   `B64SD_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !s1_adv, s1_valid_ff && $stable(s1_data_ff), "input stage lost a stalled word")
   `B64SD_ASSERT_NOW(a_no_take_when_blocked, s1_valid_ff && !s1_adv, !req_if.ready, "input taken while stage blocked")
   `B64SD_ASSERT_NOW(a_byte_status, out_valid_ff && out_data_ff.byte_valid, out_data_ff.status == ST_PROGRESS || out_data_ff.status == ST_OK, "byte word with error status")

endmodule

`default_nettype wire

@@ test/base64_stream_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// self-checking bench for the base64 stream decoder: directed messages hit
// both alphabets, padding, whitespace, bad characters and the output limit,
// then random messages run under several register settings with stalls on
// both channels; every result word is checked against a decoder kept here
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b64sd_pkg::*;

   localparam int LATENCY     = 2;
   localparam int HOLD_CYCLES = 48;
   localparam int IDLE_LIMIT  = 2000;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   b64sd_stream_if #(.payload_type(req_payload_type)) req_ch ();
   b64sd_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   base64_stream_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // local decoder state and register copies
   logic        url_cfg;
   logic [15:0] limit_cfg;
   logic [11:0] acc;
   logic [3:0]  held;
   logic        pad_flag;
   logic [15:0] count;
   logic        dropping;

   rsp_payload_type decoded_words[$];

   int chars_decoded = 0;
   int words_checked = 0;
   int error_endings = 0;
   int mismatches    = 0;
   int idle_cycles   = 0;
   bit req_gaps      = 1'b1;
   bit rsp_gaps      = 1'b1;
   bit hold_off_req  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic class_type classify_char(logic [7:0] ch, logic url);
      class_type c;
      c.kind  = KIND_DATA;
      c.value = '0;
      if (ch >= "A" && ch <= "Z") c.value = 6'(ch - "A");
      else if (ch >= "a" && ch <= "z") c.value = 6'(ch - "a" + 8'd26);
      else if (ch >= "0" && ch <= "9") c.value = 6'(ch - "0" + 8'd52);
      else if (ch == (url ? "-" : "+")) c.value = 6'd62;
      else if (ch == (url ? "_" : "/")) c.value = 6'd63;
      else if (ch == "=") c.kind = KIND_PAD;
      else if (ch == " " || ch == 8'h09 || ch == 8'h0D || ch == 8'h0A) c.kind = KIND_SPACE;
      else c.kind = KIND_INVALID;
      return c;
   endfunction

   function automatic logic [7:0] alphabet_char(logic [5:0] v, logic url);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + v - 26);
      if (v < 62) return 8'("0" + v - 52);
      if (v == 62) return url ? "-" : "+";
      return url ? "_" : "/";
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0: return " ";
         1: return 8'h09;
         2: return 8'h0D;
         default: return 8'h0A;
      endcase
   endfunction

   function automatic void clear_message();
      acc      = '0;
      held     = '0;
      pad_flag = 1'b0;
      count    = '0;
      dropping = 1'b0;
   endfunction

   function automatic rsp_payload_type result_word(logic [7:0] b, logic v, status_type st);
      rsp_payload_type w;
      w.out_byte    = b;
      w.byte_valid  = v;
      w.status      = st;
      w.message_end = (st != ST_PROGRESS);
      w.byte_count  = count;
      return w;
   endfunction

   function automatic void predict_char(logic [7:0] ch, logic last);
      class_type  c;
      status_type st = ST_PROGRESS;
      logic [7:0] b = '0;
      logic       v = 1'b0;
      if (dropping) begin
         if (last) clear_message();
      end else begin
         chars_decoded++;
         c = classify_char(ch, url_cfg);
         case (c.kind)
            KIND_INVALID: st = ST_INVALID;
            KIND_PAD: pad_flag = 1'b1;
            KIND_SPACE: ;
            default: begin
               if (pad_flag) begin
                  st = ST_PADDING;
               end else begin
                  acc  = {acc[5:0], c.value};
                  held = held + 4'd6;
                  if (held >= 4'd8) begin
                     held = held - 4'd8;
                     if (count >= limit_cfg || count == 16'hFFFF) begin
                        st = ST_OVERFLOW;
                     end else begin
                        b = 8'(acc >> held[2:0]);
                        v = 1'b1;
                        count++;
                     end
                  end
               end
            end
         endcase
         if (st != ST_PROGRESS) begin
            decoded_words.push_back(result_word(8'h00, 1'b0, st));
            if (last) clear_message();
            else dropping = 1'b1;
         end else if (last) begin
            decoded_words.push_back(result_word(b, v, ST_OK));
            clear_message();
         end else if (v) begin
            decoded_words.push_back(result_word(b, 1'b1, ST_PROGRESS));
         end
      end
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s expected %0h got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // input words feed the local decoder
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         predict_char(req_ch.payload.in_char, req_ch.payload.last_char);
   end

   // result words against the oldest decoded word
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (decoded_words.size() == 0) begin
            $error("result word %h with none expected", rsp_ch.payload);
            mismatches++;
         end else begin
            want = decoded_words.pop_front();
            words_checked++;
            if (want.status > ST_OK) error_endings++;
            check_field("out_byte", want.out_byte, rsp_ch.payload.out_byte);
            check_field("byte_valid", want.byte_valid, rsp_ch.payload.byte_valid);
            check_field("status", want.status, rsp_ch.payload.status);
            check_field("message_end", want.message_end, rsp_ch.payload.message_end);
            check_field("byte_count", want.byte_count, rsp_ch.payload.byte_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // result side ready: random stalls and one long hold
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ch.ready = 1'b0;
         end else if (hold_off_req) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   task automatic send_char(logic [7:0] ch, logic last);
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_ch.payload.in_char   = ch;
      req_ch.payload.last_char = last;
      req_ch.valid             = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   task automatic settle();
      req_ch.valid = 1'b0;
      while (decoded_words.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_URL_MODE) url_cfg = value[0];
      else limit_cfg = value;
   endtask

   task automatic configure(logic url, logic [15:0] limit);
      settle();
      write_reg(CSR_URL_MODE, {15'd0, url});
      write_reg(CSR_OUTPUT_LIMIT, limit);
   endtask

   task automatic send_random_message();
      logic [7:0] text[$];
      logic [7:0] bad;
      class_type  ck;
      int         shape;
      int         len;
      shape = $urandom_range(0, 9);
      if (shape == 9) begin
         repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
         repeat (len) begin
            if ($urandom_range(0, 7) == 0) text.push_back(blank_char());
            text.push_back(alphabet_char(6'($urandom_range(0, 63)), url_cfg));
         end
         repeat ($urandom_range(0, 2)) text.push_back("=");
         if (shape == 7) begin
            if ($urandom_range(0, 2) == 0) begin
               bad = url_cfg ? ($urandom_range(0, 1) ? "+" : "/")
                             : ($urandom_range(0, 1) ? "-" : "_");
            end else begin
               do begin
                  bad = 8'($urandom_range(0, 255));
                  ck  = classify_char(bad, url_cfg);
               end while (ck.kind != KIND_INVALID);
            end
            text[$urandom_range(0, text.size() - 1)] = bad;
         end
         if (shape == 8) begin
            text.push_back("=");
            text.push_back(alphabet_char(6'($urandom_range(0, 63)), url_cfg));
         end
         if ($urandom_range(0, 5) == 0) text.push_back(blank_char());
      end
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic test_standard_alphabet();
      send_text("////");
      send_text("AA==");
   endtask

   task automatic test_padding();
      send_text("Q=AZ");
   endtask

   task automatic test_whitespace();
      send_char(" ", 1'b0);
      send_char(8'h09, 1'b0);
      send_char(8'h0D, 1'b0);
      send_char(8'h0A, 1'b1);
   endtask

   task automatic test_invalid_chars();
      send_char("*", 1'b1);
      send_char(8'h80, 1'b0);
      send_char(8'hFF, 1'b1);
      send_char("-", 1'b1);
   endtask

   task automatic test_url_alphabet();
      configure(1'b1, OUTPUT_LIMIT_RESET);
      send_text("-_/");
   endtask

   task automatic test_output_limit();
      configure(1'b0, 16'd0);
      send_text("AA");
   endtask

   task automatic test_random_messages(logic url, logic [15:0] limit, int n_chars);
      int goal;
      configure(url, limit);
      goal = chars_decoded + n_chars;
      while (chars_decoded < goal) send_random_message();
   endtask

   task automatic test_backpressure();
      configure(1'b0, OUTPUT_LIMIT_RESET);
      hold_off_req = 1'b1;
      repeat (60) send_char(alphabet_char(6'($urandom_range(0, 63)), 1'b0), 1'b0);
      // mid message, wait for every word before going on
      settle();
      repeat (19) send_char(alphabet_char(6'($urandom_range(0, 63)), 1'b0), 1'b0);
      send_char("=", 1'b1);
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_URL_MODE;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      url_cfg        = 1'b0;
      limit_cfg      = OUTPUT_LIMIT_RESET;
      clear_message();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_standard_alphabet();
      test_padding();
      test_whitespace();
      test_invalid_chars();
      test_url_alphabet();
      test_output_limit();

      test_random_messages(1'b0, OUTPUT_LIMIT_RESET, 160);
      test_random_messages(1'b1, 16'd2, 120);
      test_random_messages(1'b0, 16'd0, 60);
      test_random_messages(1'b1, 16'd1, 60);
      test_backpressure();

      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      test_random_messages(1'b1, 16'd9, 100);
      test_random_messages(1'b0, OUTPUT_LIMIT_RESET, 100);
      settle();

      $display("decoded %0d characters into %0d result words, %0d ended on an error",
               chars_decoded, words_checked, error_endings);
      $display("both alphabets, limits 0 to 65535, stalls on both sides and a long output hold");
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/b64sd_pkg.sv
design/b64sd_stream_if.sv
design/b64sd_classify.sv
design/b64sd_decode.sv
design/base64_stream_decoder.sv
test/base64_stream_decoder_tb.sv
